FILE: rtl/stpc_pkg.sv
// ----------------------------------------------------------------------------
// stpc_pkg
// Shared widths, command codes and constants of the step pulse controller.
// ----------------------------------------------------------------------------
package stpc_pkg;

    localparam int S_TDATA_W = 64;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 96;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 27;

    localparam int FSTEPS_W = 11;
    localparam int TICK_W = 27;
    localparam int POS_W = 32;
    localparam int SPEED_IN_W = 21;
    localparam int SPEED_W = 20;
    localparam int DIV_IN_W = 5;
    localparam int CODE_W = 3;
    localparam int PERIOD_W = 32;

    localparam int MUL_A_W = 27;
    localparam int MUL_B_W = 20;
    localparam int PROD_W = MUL_A_W + MUL_B_W;
    localparam int NUM_W = 43;
    localparam int DEN_W = 35;
    localparam int CNT_W = 6;

    localparam logic [2:0] MODE_TICK     = 3'd0;
    localparam logic [2:0] MODE_MOVE     = 3'd1;
    localparam logic [2:0] MODE_MOVE_CUR = 3'd2;
    localparam logic [2:0] MODE_VELOCITY = 3'd3;
    localparam logic [2:0] MODE_SPEED    = 3'd4;
    localparam logic [2:0] MODE_DIR      = 3'd5;
    localparam logic [2:0] MODE_DIVISION = 3'd6;

    localparam logic [CODE_W-1:0] CODE_DIV1  = 3'd0;
    localparam logic [CODE_W-1:0] CODE_DIV2  = 3'd1;
    localparam logic [CODE_W-1:0] CODE_DIV4  = 3'd2;
    localparam logic [CODE_W-1:0] CODE_DIV8  = 3'd3;
    localparam logic [CODE_W-1:0] CODE_DIV16 = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_FULL_STEPS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TICK_RATE  = 2'd1;

    localparam logic [FSTEPS_W-1:0] FSTEPS_RESET = 11'd200;
    localparam logic [TICK_W-1:0]   TICK_RESET   = 27'd1000000;
    localparam logic [MUL_B_W-1:0]  MILLI_PER_MIN = 20'd60000;
    localparam logic [SPEED_W-1:0]  SPEED_SAT    = 20'hFFFFF;
    localparam logic [SPEED_IN_W-1:0] SPEED_MOST_NEG = 21'h100000;

endpackage

FILE: rtl/stepper_step_pulse_controller_core.sv
// ----------------------------------------------------------------------------
// stepper_step_pulse_controller_core
// Step/direction pulse generator with a shared multiplier and a bit-serial
// divider that recompute the step period after speed, move, velocity and
// division commands.
// Sequence: items that leave the period alone go from the command state to the
// output state; a recompute passes the command state, the numerator and
// denominator multiplier states, the divider iterations, the clamp and output.
// Flow: a new item is accepted only in idle, once the previous result is loaded.
// Reset: synchronous, active low; all motion state cleared, direction forward.
// ----------------------------------------------------------------------------
module stepper_step_pulse_controller_core (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // move_steps[31:0], speed_milli_rpm[52:32], forward_in[53], division[58:54]
    input  logic [stpc_pkg::S_TDATA_W-1:0]   s_tdata,
    // mode[2:0]
    input  logic [stpc_pkg::S_TUSER_W-1:0]   s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // step_pin[0], dir_pin[1], enable_n[2], ms1[3], ms2[4], ms3[5],
    // position[37:6], target_pos[69:38], speed_mag[89:70], status[90],
    // running[91]
    output logic [stpc_pkg::M_TDATA_W-1:0]   m_tdata,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [stpc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [stpc_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import stpc_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_EXEC = 3'd1;
    localparam logic [2:0] ST_MULN = 3'd2;
    localparam logic [2:0] ST_MULD = 3'd3;
    localparam logic [2:0] ST_DIV  = 3'd4;
    localparam logic [2:0] ST_FIN  = 3'd5;
    localparam logic [2:0] ST_OUT  = 3'd6;

    logic [2:0]            state_reg, state_next;
    logic [2:0]            mode_reg;
    logic [POS_W-1:0]      steps_reg;
    logic [SPEED_IN_W-1:0] speed_in_reg;
    logic                  fwd_in_reg;
    logic [DIV_IN_W-1:0]   div_in_reg;

    logic [FSTEPS_W-1:0]   fsteps_reg;
    logic [TICK_W-1:0]     tick_rate_reg;

    logic [POS_W-1:0]      position_reg, position_next;
    logic [POS_W-1:0]      target_reg, target_next;
    logic [SPEED_W-1:0]    speed_reg, speed_next;
    logic                  forward_reg, forward_next;
    logic                  velocity_reg, velocity_next;
    logic                  run_reg, run_next;
    logic [CODE_W-1:0]     code_reg, code_next;
    logic [PERIOD_W-1:0]   period_reg, period_next;
    logic [PERIOD_W-1:0]   phase_reg, phase_next;
    logic                  status_reg, status_next;

    logic [NUM_W-1:0]      num_reg, num_next;
    logic [DEN_W-1:0]      den_reg, den_next;
    logic [DEN_W-1:0]      rem_reg, rem_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;

    logic                  m_tvalid_reg;
    logic [M_TDATA_W-1:0]  m_tdata_reg;

    logic [MUL_A_W-1:0]    mul_a;
    logic [MUL_B_W-1:0]    mul_b;
    logic [PROD_W-1:0]     mul_p;

    logic [DEN_W:0]        trial;
    logic                  trial_ge;

    logic                  spd_neg;
    logic [SPEED_W-1:0]    spd_mag;
    logic [SPEED_IN_W-1:0] spd_negated;
    logic [POS_W-1:0]      move_target;
    logic [POS_W-1:0]      move_diff;
    logic [POS_W-1:0]      tick_pos;
    logic [PERIOD_W-1:0]   half;
    logic                  step_pin;
    logic                  out_free;
    logic                  in_xfer;

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_xfer   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign out_free  = !m_tvalid_reg || m_tready;

    // shared multiplier
    always_comb begin
        if (state_reg == ST_MULN) begin
            mul_a = tick_rate_reg;
            mul_b = MILLI_PER_MIN;
        end else begin
            mul_a = {{(MUL_A_W-FSTEPS_W){1'b0}}, fsteps_reg};
            mul_b = speed_reg;
        end
    end
    assign mul_p = mul_a * mul_b;

    // restoring divide step
    assign trial    = {rem_reg, num_reg[NUM_W-1]};
    assign trial_ge = (trial >= {1'b0, den_reg});

    // speed magnitude of the latched command
    assign spd_neg     = speed_in_reg[SPEED_IN_W-1];
    assign spd_negated = (~speed_in_reg) + 1'b1;
    always_comb begin
        if (!spd_neg) begin
            spd_mag = speed_in_reg[SPEED_W-1:0];
        end else if (speed_in_reg == SPEED_MOST_NEG) begin
            spd_mag = SPEED_SAT;
        end else begin
            spd_mag = spd_negated[SPEED_W-1:0];
        end
    end

    assign move_target = target_reg + steps_reg;
    assign move_diff   = move_target - position_reg;
    assign tick_pos    = forward_reg ? position_reg + 1'b1 : position_reg - 1'b1;

    always_comb begin
        state_next    = state_reg;
        position_next = position_reg;
        target_next   = target_reg;
        speed_next    = speed_reg;
        forward_next  = forward_reg;
        velocity_next = velocity_reg;
        run_next      = run_reg;
        code_next     = code_reg;
        period_next   = period_reg;
        phase_next    = phase_reg;
        status_next   = status_reg;
        num_next      = num_reg;
        den_next      = den_reg;
        rem_next      = rem_reg;
        cnt_next      = cnt_reg;

        case (state_reg)
            ST_IDLE: begin
                if (in_xfer) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                status_next = 1'b0;
                state_next  = ST_OUT;
                case (mode_reg)
                    MODE_TICK: begin
                        if (run_reg && speed_reg != '0) begin
                            if (period_reg == '0 || phase_reg >= period_reg - 1'b1) begin
                                phase_next    = '0;
                                position_next = tick_pos;
                                if (velocity_reg) begin
                                    target_next = tick_pos;
                                end else if (tick_pos == target_reg) begin
                                    run_next = 1'b0;
                                end
                            end else begin
                                phase_next = phase_reg + 1'b1;
                            end
                        end
                    end
                    MODE_MOVE: begin
                        velocity_next = 1'b0;
                        target_next   = move_target;
                        speed_next    = spd_mag;
                        forward_next  = !spd_neg;
                        if (spd_mag == '0) begin
                            run_next    = 1'b0;
                            status_next = 1'b1;
                        end else begin
                            state_next = ST_MULN;
                            if (move_diff != '0) begin
                                forward_next = !move_diff[POS_W-1];
                                run_next     = 1'b1;
                                phase_next   = '0;
                            end
                        end
                    end
                    MODE_MOVE_CUR: begin
                        if (speed_reg == '0) begin
                            status_next = 1'b1;
                        end else begin
                            velocity_next = 1'b0;
                            target_next   = move_target;
                            state_next    = ST_MULN;
                            if (move_diff != '0) begin
                                forward_next = !move_diff[POS_W-1];
                                run_next     = 1'b1;
                                phase_next   = '0;
                            end
                        end
                    end
                    MODE_VELOCITY: begin
                        velocity_next = 1'b1;
                        speed_next    = spd_mag;
                        forward_next  = !spd_neg;
                        if (spd_mag == '0) begin
                            run_next = 1'b0;
                        end else begin
                            run_next   = 1'b1;
                            phase_next = '0;
                            state_next = ST_MULN;
                        end
                    end
                    MODE_SPEED: begin
                        speed_next   = spd_mag;
                        forward_next = !spd_neg;
                        if (spd_mag == '0) begin
                            run_next = 1'b0;
                        end else begin
                            state_next = ST_MULN;
                        end
                    end
                    MODE_DIR: begin
                        forward_next = fwd_in_reg;
                    end
                    MODE_DIVISION: begin
                        case (div_in_reg)
                            5'd1:    code_next = CODE_DIV1;
                            5'd2:    code_next = CODE_DIV2;
                            5'd4:    code_next = CODE_DIV4;
                            5'd8:    code_next = CODE_DIV8;
                            5'd16:   code_next = CODE_DIV16;
                            default: status_next = 1'b1;
                        endcase
                        if (!status_next) begin
                            if (speed_reg == '0) begin
                                run_next = 1'b0;
                            end else begin
                                state_next = ST_MULN;
                            end
                        end
                    end
                    default: begin
                        status_next = 1'b1;
                    end
                endcase
            end
            ST_MULN: begin
                num_next   = mul_p[NUM_W-1:0];
                state_next = ST_MULD;
            end
            ST_MULD: begin
                den_next   = {{(DEN_W-31){1'b0}}, mul_p[30:0]} << code_reg;
                rem_next   = '0;
                cnt_next   = CNT_W'(NUM_W - 1);
                state_next = ST_DIV;
            end
            ST_DIV: begin
                rem_next = trial_ge ? DEN_W'(trial - {1'b0, den_reg}) : trial[DEN_W-1:0];
                num_next = {num_reg[NUM_W-2:0], trial_ge};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (den_reg == '0 || num_reg[NUM_W-1:PERIOD_W] != '0) begin
                    period_next = '1;
                end else if (num_reg[PERIOD_W-1:0] < PERIOD_W'(2)) begin
                    period_next = PERIOD_W'(2);
                end else begin
                    period_next = num_reg[PERIOD_W-1:0];
                end
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign half     = {1'b0, period_reg[PERIOD_W-1:1]};
    assign step_pin = run_reg && half != '0 && phase_reg < half - 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            fsteps_reg    <= FSTEPS_RESET;
            tick_rate_reg <= TICK_RESET;
            position_reg  <= '0;
            target_reg    <= '0;
            speed_reg     <= '0;
            forward_reg   <= 1'b1;
            velocity_reg  <= 1'b0;
            run_reg       <= 1'b0;
            code_reg      <= CODE_DIV1;
            period_reg    <= '0;
            phase_reg     <= '0;
            status_reg    <= 1'b0;
            cnt_reg       <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            position_reg <= position_next;
            target_reg   <= target_next;
            speed_reg    <= speed_next;
            forward_reg  <= forward_next;
            velocity_reg <= velocity_next;
            run_reg      <= run_next;
            code_reg     <= code_next;
            period_reg   <= period_next;
            phase_reg    <= phase_next;
            status_reg   <= status_next;
            cnt_reg      <= cnt_next;
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_FULL_STEPS) begin
                    fsteps_reg <= cfg_data[FSTEPS_W-1:0];
                end else if (cfg_index == CFG_TICK_RATE) begin
                    tick_rate_reg <= cfg_data[TICK_W-1:0];
                end
            end
            if (state_reg == ST_OUT && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // payload: hold the command and divider operands, load the result
    always_ff @(posedge aclk) begin
        num_reg <= num_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
        if (in_xfer) begin
            mode_reg     <= s_tuser[2:0];
            steps_reg    <= s_tdata[31:0];
            speed_in_reg <= s_tdata[52:32];
            fwd_in_reg   <= s_tdata[53];
            div_in_reg   <= s_tdata[58:54];
        end
        if (state_reg == ST_OUT && out_free) begin
            m_tdata_reg <= {
                4'b0,
                run_reg,
                status_reg,
                speed_reg,
                target_reg,
                position_reg,
                (code_reg == CODE_DIV16),
                (code_reg == CODE_DIV4 || code_reg == CODE_DIV8 || code_reg == CODE_DIV16),
                (code_reg == CODE_DIV2 || code_reg == CODE_DIV8 || code_reg == CODE_DIV16),
                !run_reg,
                forward_reg,
                step_pin
            };
        end
    end

endmodule
